>>> rtl/pbrf_pkg.sv
// Shared types and codes for the page bitmap range free block.
// No dependencies; used by the controller, datapath and top level.
package pbrf_pkg;

  localparam int ADDR_W = 48;
  localparam int WORD_W = 64;
  localparam int CNT_W  = 13;
  localparam int IDX_W  = 6;
  localparam int OP_W   = 2;
  localparam int KIND_W = 2;

  localparam logic [OP_W-1:0] OP_RELEASE = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE   = 2'd1;
  localparam logic [OP_W-1:0] OP_READ    = 2'd2;

  localparam logic [KIND_W-1:0] KIND_TYPED = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RAW   = 2'd1;

  // controller -> datapath
  typedef struct packed {
    logic clr;        // zero one RAM row, advance sweep
    logic load;       // capture input beat
    logic calc;       // page index from address
    logic setup;      // run bounds, error flag
    logic rd_first;   // read first word of run
    logic mod;        // write back current word, read next
    logic wr_widx;    // op write: store word pair
    logic rd_widx;    // op read: fetch word pair
    logic load_out;   // fill output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic            clr_last;
    logic [OP_W-1:0] op;
    logic            page_oob;
    logic            last_word;
  } sts_t;

endpackage

>>> rtl/pbrf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pbrf_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/pbrf_ctrl.sv
// Sequencing FSM for the page bitmap range free block.
// Depends on pbrf_pkg (cmd_t, sts_t, op codes).
module pbrf_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  input  pbrf_pkg::sts_t  sts,
  output pbrf_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CALC  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_MOD   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_tready = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc = 1'b1;
        case (sts.op)
          pbrf_pkg::OP_RELEASE: state_nxt = S_CHECK;
          pbrf_pkg::OP_WRITE: begin
            cmd.wr_widx = 1'b1;
            state_nxt   = S_OUT;
          end
          pbrf_pkg::OP_READ: begin
            cmd.rd_widx = 1'b1;
            state_nxt   = S_OUT;
          end
          default: state_nxt = S_OUT;
        endcase
      end
      S_CHECK: begin
        cmd.setup = 1'b1;
        if (sts.page_oob) begin
          state_nxt = S_OUT;
        end else begin
          cmd.rd_first = 1'b1;
          state_nxt    = S_MOD;
        end
      end
      S_MOD: begin
        cmd.mod = 1'b1;
        if (sts.last_word) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  // a finished result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_tready))
    else $error("result loaded over a stalled beat");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("loaded result not presented");

  a_accept_calc: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_CALC))
    else $error("accepted beat not processed");

  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOD && sts.last_word) |=> (state_r == S_OUT))
    else $error("run did not end at last word");

endmodule

>>> rtl/pbrf_dp.sv
// Datapath: input registers, page index math, run masks, bitmap RAM, result register.
// Depends on pbrf_pkg and pbrf_ram.
module pbrf_dp #(
  parameter int BITMAP_WORDS = 64,
  parameter int PAGE_SHIFT   = 21
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [pbrf_pkg::ADDR_W-1:0]   cfg_wr_data,
  input  logic [pbrf_pkg::OP_W-1:0]     op_in,
  input  logic [pbrf_pkg::ADDR_W-1:0]   addr_in,
  input  logic [pbrf_pkg::KIND_W-1:0]   kind_in,
  input  logic [pbrf_pkg::CNT_W-1:0]    cnt_in,
  input  logic [pbrf_pkg::IDX_W-1:0]    widx_in,
  input  logic [pbrf_pkg::WORD_W-1:0]   hdr_in,
  input  logic [pbrf_pkg::WORD_W-1:0]   occ_in,
  input  pbrf_pkg::cmd_t                cmd,
  output pbrf_pkg::sts_t                sts,
  output logic [pbrf_pkg::WORD_W-1:0]   hdr_out,
  output logic [pbrf_pkg::WORD_W-1:0]   occ_out,
  output logic                          err_out
);

  localparam int WW     = pbrf_pkg::WORD_W;
  localparam int AW     = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam int LIMIT  = BITMAP_WORDS * 64;
  localparam int PG_W   = AW + 6;
  localparam int RAW_W  = pbrf_pkg::ADDR_W - PAGE_SHIFT;
  localparam int END_W  = ((PG_W > pbrf_pkg::CNT_W) ? PG_W : pbrf_pkg::CNT_W) + 1;
  localparam int IDXC_W = 12;

  // captured beat
  logic [pbrf_pkg::OP_W-1:0]   op_r;
  logic [pbrf_pkg::ADDR_W-1:0] addr_r;
  logic [pbrf_pkg::KIND_W-1:0] kind_r;
  logic [pbrf_pkg::CNT_W-1:0]  cnt_r;
  logic [pbrf_pkg::IDX_W-1:0]  widx_r;
  logic [WW-1:0]               hdr_in_r, occ_in_r;
  logic [pbrf_pkg::ADDR_W-1:0] base_r;

  // run state
  logic [RAW_W-1:0] page_r;
  logic [5:0]       lo_r;
  logic [6:0]       hi_r;
  logic [AW-1:0]    last_r, cur_r, clr_cnt_r;
  logic             first_r, occ_en_r, err_r;

  logic [WW-1:0] hdr_out_r, occ_out_r;
  logic          err_out_r;

  // ram ports, {occupancy, header}
  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [2*WW-1:0] ram_wdata, ram_rdata;

  logic [pbrf_pkg::ADDR_W-1:0] diff;
  logic [PG_W-1:0]             pg;
  logic [pbrf_pkg::CNT_W-1:0]  cnt_eff;
  logic [END_W-1:0]            end_raw, end_cl, end_m1;
  logic                        clip, idx_ok, page_oob;
  logic [AW-1:0]               widx_a, pg_word;
  logic [6:0]                  lo_eff, hi_eff;
  logic [WW-1:0]               occ_mask, hdr_mask, hdr_cur, occ_cur;

  assign diff     = addr_r - base_r;
  assign page_oob = page_r >= RAW_W'(LIMIT);
  assign pg       = page_r[PG_W-1:0];
  assign pg_word  = pg[PG_W-1:6];
  assign idx_ok   = IDXC_W'(widx_r) < IDXC_W'(BITMAP_WORDS);
  assign widx_a   = AW'(widx_r);

  // typed/raw pages and unit blobs touch one page
  assign cnt_eff = (kind_r == pbrf_pkg::KIND_TYPED || kind_r == pbrf_pkg::KIND_RAW ||
                    cnt_r == pbrf_pkg::CNT_W'(1)) ? pbrf_pkg::CNT_W'(1) : cnt_r;
  assign end_raw = END_W'(pg) + END_W'(cnt_eff);
  assign clip    = end_raw > END_W'(LIMIT);
  assign end_cl  = clip ? END_W'(LIMIT) : end_raw;
  assign end_m1  = end_cl - END_W'(1);

  // per-word masks
  assign lo_eff = first_r ? {1'b0, lo_r} : 7'd0;
  assign hi_eff = (cur_r == last_r) ? hi_r : 7'd64;
  always_comb begin
    for (int i = 0; i < WW; i++) begin
      occ_mask[i] = occ_en_r && (7'(i) >= lo_eff) && (7'(i) < hi_eff);
    end
  end
  assign hdr_mask = first_r ? (WW'(1) << lo_r) : '0;
  assign hdr_cur  = ram_rdata[WW-1:0];
  assign occ_cur  = ram_rdata[2*WW-1:WW];

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_r;
    ram_wdata = {occ_cur & ~occ_mask, hdr_cur & ~hdr_mask};
    if (cmd.clr) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = '0;
    end else if (cmd.wr_widx) begin
      ram_we    = idx_ok;
      ram_waddr = widx_a;
      ram_wdata = {occ_in_r, hdr_in_r};
    end else if (cmd.mod) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = cur_r + AW'(1);
    if (cmd.rd_widx) begin
      ram_re    = 1'b1;
      ram_raddr = widx_a;
    end else if (cmd.rd_first) begin
      ram_re    = 1'b1;
      ram_raddr = pg_word;
    end else if (cmd.mod) begin
      ram_re = (cur_r != last_r);
    end
  end

  pbrf_ram #(
    .WIDTH (2 * WW),
    .DEPTH (BITMAP_WORDS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r    <= '0;
      clr_cnt_r <= '0;
    end else begin
      if (cfg_wr_en) base_r <= cfg_wr_data;
      if (cmd.clr) clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= op_in;
      addr_r   <= addr_in;
      kind_r   <= kind_in;
      cnt_r    <= cnt_in;
      widx_r   <= widx_in;
      hdr_in_r <= hdr_in;
      occ_in_r <= occ_in;
    end
    if (cmd.calc) begin
      page_r <= RAW_W'(diff >> PAGE_SHIFT);
    end
    if (cmd.setup) begin
      err_r    <= page_oob | clip;
      lo_r     <= pg[5:0];
      occ_en_r <= (cnt_eff != '0);
      hi_r     <= {1'b0, end_m1[5:0]} + 7'd1;
      last_r   <= (cnt_eff != '0) ? end_m1[PG_W-1:6] : pg_word;
      cur_r    <= pg_word;
      first_r  <= 1'b1;
    end
    if (cmd.mod) begin
      cur_r   <= cur_r + AW'(1);
      first_r <= 1'b0;
    end
    if (cmd.load_out) begin
      hdr_out_r <= (op_r == pbrf_pkg::OP_READ && idx_ok) ? hdr_cur : '0;
      occ_out_r <= (op_r == pbrf_pkg::OP_READ && idx_ok) ? occ_cur : '0;
      err_out_r <= (op_r == pbrf_pkg::OP_RELEASE) && err_r;
    end
  end

  assign sts.clr_last  = (clr_cnt_r == AW'(BITMAP_WORDS - 1));
  assign sts.op        = op_r;
  assign sts.page_oob  = page_oob;
  assign sts.last_word = (cur_r == last_r);

  assign hdr_out = hdr_out_r;
  assign occ_out = occ_out_r;
  assign err_out = err_out_r;

endmodule

>>> rtl/page_bitmap_range_free.sv
// Top level of the page bitmap range free block.
// Depends on pbrf_pkg, pbrf_ctrl, pbrf_dp (which holds pbrf_ram).
// Usage:
//  - in_* is the request stream, one beat per operation: release a span,
//    write a header/occupancy word pair, or read one back. in_tuser is the op.
//  - out_* returns exactly one beat per request: the word pair for a read,
//    zeros otherwise, and range_error in out_tuser for a release that is clipped or starts past the bitmap end.
//  - cfg_wr_en/cfg_wr_data load the heap base address; write it only while idle.
// Sequence (accept in IDLE; result loaded in OUT, then back to IDLE):
//  - write, read and unused ops: CALC, then OUT.
//  - release: CALC, CHECK, then one MOD per bitmap word the span touches
//    (one word for a single page), then OUT; one read-modify-write per word
//    per cycle, next word read overlapping current write-back.
//  - a release whose start page is past the bitmap end: CALC, CHECK, then OUT.
// Reset:
//  - after rst_n, a clearing pass zeroes the bitmap RAM, one word a cycle,
//    all BITMAP_WORDS words, with in_tready low; cfg writes are taken as ever.
// Backpressure:
//  - the result sits in an output register; the next request is accepted
//    while it waits. A second result waits in the FSM until out_tready.
module page_bitmap_range_free #(
  parameter int BITMAP_WORDS = 64,
  parameter int PAGE_SHIFT   = 21
) (
  input  logic         clk,
  input  logic         rst_n,
  // config
  input  logic         cfg_wr_en,
  input  logic [47:0]  cfg_wr_data,    // heap base address
  // request stream
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata, low to high: span_address[47:0], span_kind[49:48],
  // page_count[62:50], word_index[68:63], header_word_in[132:69],
  // occupy_word_in[196:133], zero pad[199:197]
  input  logic [199:0] in_tdata,
  input  logic [1:0]   in_tuser,       // op
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata, low to high: header_word_out[63:0], occupy_word_out[127:64]
  output logic [127:0] out_tdata,
  output logic         out_tuser       // range_error
);

  pbrf_pkg::cmd_t cmd;
  pbrf_pkg::sts_t sts;

  logic [pbrf_pkg::WORD_W-1:0] hdr_out, occ_out;

  pbrf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  pbrf_dp #(
    .BITMAP_WORDS (BITMAP_WORDS),
    .PAGE_SHIFT   (PAGE_SHIFT)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .op_in       (in_tuser),
    .addr_in     (in_tdata[47:0]),
    .kind_in     (in_tdata[49:48]),
    .cnt_in      (in_tdata[62:50]),
    .widx_in     (in_tdata[68:63]),
    .hdr_in      (in_tdata[132:69]),
    .occ_in      (in_tdata[196:133]),
    .cmd         (cmd),
    .sts         (sts),
    .hdr_out     (hdr_out),
    .occ_out     (occ_out),
    .err_out     (out_tuser)
  );

  assign out_tdata = {occ_out, hdr_out};

endmodule

>>> tb/sv/pbrf_free_checker.sv
// Checker for page_bitmap_range_free: watches config, request and result beats,
// keeps its own copy of both page bitmaps and compares every result beat.
// Depends on pbrf_pkg for the op and kind codes.
`timescale 1ns / 1ps

module pbrf_free_checker #(
  parameter int BITMAP_WORDS = 64,
  parameter int PAGE_SHIFT   = 21
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [47:0]  cfg_wr_data,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [199:0] in_tdata,
  input  logic [1:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [127:0] out_tdata,
  input  logic         out_tuser,
  output int           results_seen,
  output int           mismatches
);

  typedef struct packed {
    logic [63:0] hdr;
    logic [63:0] occ;
    logic        clipped;
  } free_reply_t;

  logic [47:0]  arena_base;
  logic [63:0]  hdr_map [BITMAP_WORDS];
  logic [63:0]  occ_map [BITMAP_WORDS];
  free_reply_t  expected_replies[$];
  free_reply_t  want, got;
  int           n_bad;

  // clears header bit and occupancy run; returns the clip flag
  function automatic logic free_span(input logic [47:0] addr, input logic [1:0] kind,
                                     input logic [12:0] cnt);
    longint unsigned limit, page, stop, p;
    logic [47:0]     offset;
    logic            clipped;
    limit   = BITMAP_WORDS * 64;
    offset  = addr - arena_base;
    page    = offset >> PAGE_SHIFT;
    clipped = 1'b0;
    if (page >= limit) return 1'b1;
    hdr_map[page / 64][page % 64] = 1'b0;
    stop = page + ((kind == pbrf_pkg::KIND_TYPED || kind == pbrf_pkg::KIND_RAW) ?
                   64'd1 : 64'(cnt));
    if (stop > limit) begin
      stop    = limit;
      clipped = 1'b1;
    end
    for (p = page; p < stop; p++) occ_map[p / 64][p % 64] = 1'b0;
    return clipped;
  endfunction

  function automatic free_reply_t apply_request(input logic [1:0] op, input logic [199:0] beat);
    free_reply_t res;
    logic [5:0]  widx;
    res  = '0;
    widx = beat[68:63];
    case (op)
      pbrf_pkg::OP_RELEASE: res.clipped = free_span(beat[47:0], beat[49:48], beat[62:50]);
      pbrf_pkg::OP_WRITE: begin
        if (widx < BITMAP_WORDS) begin
          hdr_map[widx] = beat[132:69];
          occ_map[widx] = beat[196:133];
        end
      end
      pbrf_pkg::OP_READ: begin
        if (widx < BITMAP_WORDS) begin
          res.hdr = hdr_map[widx];
          res.occ = occ_map[widx];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      arena_base = '0;
      for (int w = 0; w < BITMAP_WORDS; w++) begin
        hdr_map[w] = '0;
        occ_map[w] = '0;
      end
      expected_replies.delete();
      n_bad = 0;
      results_seen <= 0;
      mismatches   <= 0;
    end else begin
      if (cfg_wr_en) arena_base = cfg_wr_data;
      // a result beat always follows its own request: compare first
      if (out_tvalid && out_tready) begin
        got = {out_tdata[63:0], out_tdata[127:64], out_tuser};
        results_seen <= results_seen + 1;
        if (expected_replies.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("%0t: result beat with none expected: hdr=%h occ=%h err=%b",
                     $realtime, got.hdr, got.occ, got.clipped);
        end else begin
          want = expected_replies.pop_front();
          if (got.hdr !== want.hdr || got.occ !== want.occ || got.clipped !== want.clipped) begin
            n_bad++;
            if (n_bad <= 10)
              $display("%0t: mismatch: hdr exp=%h got=%h occ exp=%h got=%h err exp=%b got=%b",
                       $realtime, want.hdr, got.hdr, want.occ, got.occ,
                       want.clipped, got.clipped);
          end
        end
      end
      if (in_tvalid && in_tready) expected_replies.push_back(apply_request(in_tuser, in_tdata));
      mismatches <= n_bad;
    end
  end

endmodule

>>> tb/sv/tb_top.sv
// Top of the page_bitmap_range_free testbench: clock, reset, request and
// config stimulus, random backpressure and the verdict.
// Depends on pbrf_pkg, the block under test and pbrf_free_checker.
`timescale 1ns / 1ps

module tb_top;

  localparam int BITMAP_WORDS = 64;
  localparam int PAGE_SHIFT   = 21;
  localparam int LAST_PAGE    = BITMAP_WORDS * 64 - 1;
  localparam int PHASE_BEATS  = 106;

  // codes the package leaves unnamed
  localparam logic [1:0] OP_SPARE   = 2'd3;
  localparam logic [1:0] KIND_BLOB  = 2'd2;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  logic         clk         = 1'b0;
  logic         rst_n       = 1'b0;
  logic         cfg_wr_en   = 1'b0;
  logic [47:0]  cfg_wr_data = '0;
  logic         in_tvalid   = 1'b0;
  logic         in_tready;
  // low to high: span_address, span_kind, page_count, word_index,
  // header_word_in, occupy_word_in, zero pad
  logic [199:0] in_tdata    = '0;
  logic [1:0]   in_tuser    = '0;    // op
  logic         out_tvalid;
  logic         out_tready  = 1'b0;
  logic [127:0] out_tdata;           // low to high: header_word_out, occupy_word_out
  logic         out_tuser;           // range_error

  int           results_seen;
  int           mismatches;
  int           beats_sent     = 0;
  int           send_idle_pct  = 0;
  int           recv_stall_pct = 0;
  logic [47:0]  cur_base       = '0;  // base address as last written

  always #4 clk = ~clk;

  page_bitmap_range_free #(
    .BITMAP_WORDS(BITMAP_WORDS),
    .PAGE_SHIFT  (PAGE_SHIFT)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  pbrf_free_checker #(
    .BITMAP_WORDS(BITMAP_WORDS),
    .PAGE_SHIFT  (PAGE_SHIFT)
  ) u_free_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .results_seen(results_seen),
    .mismatches  (mismatches)
  );

  // Receiver: one fresh ready decision per edge, stall rate set by the phase.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [47:0] rand48();
    return 48'({$urandom, $urandom});
  endfunction

  // Mostly ones, so that a release has bits to clear and the read shows it.
  function automatic logic [63:0] dense_word();
    case ($urandom_range(3))
      0:       return '1;
      1:       return rand64() | rand64();
      2:       return rand64();
      default: return rand64() | rand64() | rand64();
    endcase
  endfunction

  // Span address that lands on a given page, random offset inside the page.
  function automatic logic [47:0] span_addr(input int unsigned page);
    return cur_base + (48'(page) << PAGE_SHIFT) +
           48'($urandom_range((1 << PAGE_SHIFT) - 1));
  endfunction

  // Page counts: spans of up to 140 pages most often, then short, zero and huge runs.
  function automatic logic [12:0] pick_count();
    int unsigned s;
    s = $urandom_range(19);
    if (s < 8)       return 13'($urandom_range(1, 140));
    else if (s < 14) return 13'($urandom_range(0, 8));
    else if (s < 17) return 13'($urandom_range(0, 1200));
    else             return 13'($urandom_range(0, 8191));
  endfunction

  function automatic logic [1:0] pick_kind();
    if ($urandom_range(9) < 7) return KIND_BLOB;
    return 2'($urandom_range(3));
  endfunction

  // One request beat. Optional idle cycles first; the previous beat was taken
  // at this edge, so valid is either dropped or reloaded here, never both.
  task automatic send_beat(input logic [1:0] op, input logic [47:0] addr,
                           input logic [1:0] kind, input logic [12:0] cnt,
                           input logic [5:0] widx, input logic [63:0] hdr_w,
                           input logic [63:0] occ_w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {3'b000, occ_w, hdr_w, widx, cnt, kind, addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    beats_sent++;
  endtask

  // Fields a given op ignores still carry random bits.
  task automatic release_req(input logic [47:0] addr, input logic [1:0] kind,
                             input logic [12:0] cnt);
    send_beat(pbrf_pkg::OP_RELEASE, addr, kind, cnt, 6'($urandom), rand64(), rand64());
  endtask

  task automatic write_words(input int unsigned widx, input logic [63:0] hdr_w,
                             input logic [63:0] occ_w);
    send_beat(pbrf_pkg::OP_WRITE, rand48(), 2'($urandom), 13'($urandom), 6'(widx),
              hdr_w, occ_w);
  endtask

  task automatic read_words(input int unsigned widx);
    send_beat(pbrf_pkg::OP_READ, rand48(), 2'($urandom), 13'($urandom), 6'(widx),
              rand64(), rand64());
  endtask

  // Hold off until every result beat is back; block is idle after that since
  // each request yields exactly one result.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (results_seen != beats_sent) @(posedge clk);
  endtask

  task automatic set_base(input logic [47:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    cur_base     = value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Well-formed sequence: fill a word or two, release a span starting there,
  // read the words back so the cleared bits are visible.
  task automatic release_window();
    int unsigned w;
    w = $urandom_range(BITMAP_WORDS - 1);
    write_words(w, dense_word(), dense_word());
    if (w < BITMAP_WORDS - 1) write_words(w + 1, dense_word(), dense_word());
    release_req(span_addr(w * 64 + $urandom_range(63)), pick_kind(), pick_count());
    read_words(w);
    if (w < BITMAP_WORDS - 1) read_words(w + 1);
    if (w < BITMAP_WORDS - 2 && $urandom_range(1)) read_words(w + 2);
  endtask

  // Single loose beat: refill, release anywhere, read anywhere, or noise.
  task automatic random_item();
    int unsigned r, s;
    logic [47:0] addr;
    r = $urandom_range(99);
    if (r < 25) begin
      write_words($urandom_range(BITMAP_WORDS - 1), dense_word(), dense_word());
    end else if (r < 62) begin
      s = $urandom_range(19);
      if (s < 14)      addr = span_addr($urandom_range(LAST_PAGE));
      else if (s < 17) addr = span_addr($urandom_range(LAST_PAGE - 130, LAST_PAGE + 100));
      else             addr = rand48();
      release_req(addr, pick_kind(), pick_count());
    end else if (r < 94) begin
      read_words($urandom_range(BITMAP_WORDS - 1));
    end else begin
      send_beat(OP_SPARE, rand48(), 2'($urandom), 13'($urandom), 6'($urandom),
                rand64(), rand64());
    end
  endtask

  initial begin
    int target;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, base address still at its reset value of zero.
    write_words(0, '1, '1);
    write_words(1, '1, '1);
    write_words(BITMAP_WORDS - 1, '1, '1);
    write_words(2, '0, '0);
    release_req(48'h1F_FFFF, pbrf_pkg::KIND_TYPED, 13'h1FFF);  // page 0, count ignored
    release_req(span_addr(65), pbrf_pkg::KIND_RAW, 13'd40);    // raw page, one bit
    release_req(span_addr(3), KIND_BLOB, 13'd1);        // blob of one page
    release_req(span_addr(5), KIND_BLOB, 13'd0);        // header bit only
    release_req(span_addr(10), KIND_BLOB, 13'd70);      // crosses into word 1
    release_req(span_addr(70), KIND_SPARE, 13'd3);      // spare kind acts as blob
    read_words(0);
    read_words(1);
    release_req(span_addr(LAST_PAGE - 5), KIND_BLOB, 13'd100);  // clipped at end
    release_req(48'hFFFF_FFFF_FFFF, KIND_BLOB, 13'd4);  // start past the end
    read_words(BITMAP_WORDS - 1);
    send_beat(OP_SPARE, '1, 2'($urandom), '1, '1, '1, '1);
    release_req(span_addr(0), KIND_BLOB, 13'h1FFF);     // whole map, clipped
    read_words(BITMAP_WORDS - 1);
    read_words(2);

    // Address below base: subtraction wraps, lands on page 2.
    drain();
    set_base(48'hFFFF_FFFF_FFFF);
    write_words(0, '1, '1);
    release_req(48'h3F_FFFF, KIND_BLOB, 13'd2);
    read_words(0);

    // Random phases: quiet, slow sender, slow receiver, both a little.
    // Each starts from an idle block so the base can be rewritten.
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          set_base('0);
        end
        1: begin
          send_idle_pct  = 55;
          recv_stall_pct = 0;
          set_base(rand48());
        end
        2: begin
          // near the top of the address space, so spans wrap past zero
          send_idle_pct  = 0;
          recv_stall_pct = 55;
          set_base(48'hFFFF_FFFF_FFFF - (48'($urandom_range(2000)) << PAGE_SHIFT));
        end
        default: begin
          send_idle_pct  = 14;
          recv_stall_pct = 14;
          set_base(rand48() & ~48'((1 << PAGE_SHIFT) - 1));
        end
      endcase
      target = beats_sent + PHASE_BEATS;
      while (beats_sent < target) begin
        if ($urandom_range(99) < 60) release_window();
        else                         random_item();
      end
    end

    drain();
    // catch any stray result beat after the last expected one
    repeat (80) @(posedge clk);
    if (mismatches == 0 && results_seen == beats_sent) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

>>> page_bitmap_range_free.f
rtl/pbrf_pkg.sv
rtl/pbrf_ram.sv
rtl/pbrf_ctrl.sv
rtl/pbrf_dp.sv
rtl/page_bitmap_range_free.sv
tb/sv/pbrf_free_checker.sv
tb/sv/tb_top.sv
